@@ design/rtd_pkg.sv @@
`timescale 1ns / 1ps

package rtd_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    localparam int LI_W    = 10;
    localparam int MIN_W   = 11;
    localparam int MAX_W   = 12;
    localparam int SCALE_W = 7;
    localparam int VAL_W   = 16;
    localparam int OUT_W   = 16;
    localparam int STAT_W  = 2;

    localparam int NUM_W  = VAL_W + SCALE_W;
    localparam int QCNT_W = $clog2(SCALE_W);
    localparam int DEG_W  = (((IDX_W + 1) > MAX_W) ? (IDX_W + 1) : MAX_W) + 1;
    localparam int TEMP_W = DEG_W + SCALE_W + 2;

    localparam int OUT_MAX = 32767;
    localparam int OUT_MIN = -32768;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_LAST_INDEX  = 2'd0;
    localparam logic [1:0] REG_MIN_DEGREES = 2'd1;
    localparam logic [1:0] REG_MAX_DEGREES = 2'd2;
    localparam logic [1:0] REG_SCALE       = 2'd3;

    localparam logic [LI_W-1:0]    RST_LAST_INDEX  = LI_W'(1023);
    localparam logic [MIN_W-1:0]   RST_MIN_DEGREES = MIN_W'(-200);
    localparam logic [MAX_W-1:0]   RST_MAX_DEGREES = MAX_W'(823);
    localparam logic [SCALE_W-1:0] RST_SCALE       = SCALE_W'(10);

    localparam logic REQ_WRITE   = 1'b0;
    localparam logic REQ_CONVERT = 1'b1;

    localparam logic [STAT_W-1:0] CLAMP_NONE = 2'd0;
    localparam logic [STAT_W-1:0] CLAMP_MIN  = 2'd1;
    localparam logic [STAT_W-1:0] CLAMP_MAX  = 2'd2;

    typedef enum logic [2:0] {
        RD_ZERO,
        RD_TOP,
        RD_MID,
        RD_LO,
        RD_LOM1
    } t_rd_sel;

    typedef struct packed {
        logic    wr_entry;
        logic    ld_req;
        t_rd_sel rd_sel;
        logic    clamp_min;
        logic    clamp_max;
        logic    init_search;
        logic    step_search;
        logic    ld_upper;
        logic    ld_lower;
        logic    ld_mul;
        logic    div_step;
        logic    ld_out;
    } t_cmd;

    typedef struct packed {
        logic data_lt;
        logic data_gt;
        logic search_done;
        logic div_last;
    } t_sts;

    typedef struct packed {
        logic [LI_W-1:0]    last_index;
        logic [MIN_W-1:0]   min_degrees;
        logic [MAX_W-1:0]   max_degrees;
        logic [SCALE_W-1:0] scale;
    } t_cfg;

endpackage

@@ design/rtd_ram.sv @@
`timescale 1ns / 1ps

module rtd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/rtd_ctrl.sv @@
`timescale 1ns / 1ps

module rtd_ctrl import rtd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_req_type,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_RD0    = 10'b00_0000_0010,
        S_RDTOP  = 10'b00_0000_0100,
        S_SEARCH = 10'b00_0000_1000,
        S_CMP    = 10'b00_0001_0000,
        S_GETUP  = 10'b00_0010_0000,
        S_GETLO  = 10'b00_0100_0000,
        S_MUL    = 10'b00_1000_0000,
        S_DIV    = 10'b01_0000_0000,
        S_FIN    = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_cmd   w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd = '0;
        w_cmd.rd_sel = RD_ZERO;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_req_type == REQ_WRITE) begin
                        w_cmd.wr_entry = 1'b1;
                    end else begin
                        w_cmd.ld_req = 1'b1;
                        n_state = S_RD0;
                    end
                end
            end
            S_RD0: begin
                if (!i_sts.data_lt) begin
                    w_cmd.clamp_min = 1'b1;
                    n_state = S_FIN;
                end else begin
                    w_cmd.rd_sel = RD_TOP;
                    n_state = S_RDTOP;
                end
            end
            S_RDTOP: begin
                if (!i_sts.data_gt) begin
                    w_cmd.clamp_max = 1'b1;
                    n_state = S_FIN;
                end else begin
                    w_cmd.init_search = 1'b1;
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (i_sts.search_done) begin
                    w_cmd.rd_sel = RD_LO;
                    n_state = S_GETUP;
                end else begin
                    w_cmd.rd_sel = RD_MID;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                w_cmd.step_search = 1'b1;
                n_state = S_SEARCH;
            end
            S_GETUP: begin
                w_cmd.ld_upper = 1'b1;
                w_cmd.rd_sel = RD_LOM1;
                n_state = S_GETLO;
            end
            S_GETLO: begin
                w_cmd.ld_lower = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                w_cmd.ld_mul = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                w_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.ld_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_cmd.ld_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

endmodule

@@ design/rtd_dpath.sv @@
`timescale 1ns / 1ps

module rtd_dpath import rtd_pkg::*; (
    input  logic                     i_clk,
    input  t_cfg                     i_cfg,
    input  t_cmd                     i_cmd,
    input  logic [9:0]               i_entry_index,
    input  logic [VAL_W-1:0]         i_entry_value,
    input  logic [VAL_W-1:0]         i_resistance,
    output t_sts                     o_sts,
    output logic signed [OUT_W-1:0]  o_temperature,
    output logic [STAT_W-1:0]        o_clamp_status
);

    logic [VAL_W-1:0]         r_res;
    logic [IDX_W-1:0]         r_lo;
    logic [IDX_W-1:0]         r_hi;
    logic [VAL_W-1:0]         r_upper;
    logic signed [DEG_W-1:0]  r_deg;
    logic                     r_use_frac;
    logic [STAT_W-1:0]        r_status;
    logic [VAL_W-1:0]         r_diff;
    logic [VAL_W-1:0]         r_den;
    logic [NUM_W-1:0]         r_rem;
    logic [NUM_W-1:0]         r_dsh;
    logic [SCALE_W-1:0]       r_quo;
    logic [QCNT_W-1:0]        r_cnt;
    logic signed [OUT_W-1:0]  r_temp;
    logic [STAT_W-1:0]        r_stat_out;

    logic [IDX_W-1:0]         w_top;
    logic [IDX_W:0]           w_sum;
    logic [IDX_W-1:0]         w_mid;
    logic [IDX_W-1:0]         w_rd_addr;
    logic [VAL_W-1:0]         w_rd_data;
    logic                     w_wr_en;
    logic                     w_hit;
    logic signed [DEG_W-1:0]  w_min_ext;
    logic signed [DEG_W-1:0]  w_max_ext;
    logic signed [DEG_W-1:0]  w_deg_base;
    logic [NUM_W-1:0]         w_prod;
    logic [NUM_W:0]           w_trial;
    logic                     w_ge;
    logic signed [TEMP_W-1:0] w_deg_ext;
    logic signed [TEMP_W-1:0] w_scale_ext;
    logic signed [TEMP_W-1:0] w_frac_ext;
    logic signed [TEMP_W-1:0] w_temp;
    logic signed [OUT_W-1:0]  w_temp_sat;

    always_comb begin
        if (32'(i_cfg.last_index) > 32'(TABLE_DEPTH - 1)) begin
            w_top = IDX_W'(TABLE_DEPTH - 1);
        end else if (i_cfg.last_index == '0) begin
            w_top = IDX_W'(1);
        end else begin
            w_top = IDX_W'(i_cfg.last_index);
        end
    end

    assign w_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid = w_sum[IDX_W:1];

    always_comb begin
        case (i_cmd.rd_sel)
            RD_ZERO: w_rd_addr = '0;
            RD_TOP:  w_rd_addr = w_top;
            RD_MID:  w_rd_addr = w_mid;
            RD_LO:   w_rd_addr = r_lo;
            RD_LOM1: w_rd_addr = r_lo - IDX_W'(1);
            default: w_rd_addr = '0;
        endcase
    end

    assign w_wr_en = i_cmd.wr_entry && (32'(i_entry_index) < TABLE_DEPTH);

    rtd_ram #(
        .WIDTH(VAL_W),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (IDX_W'(i_entry_index)),
        .i_wr_data (i_entry_value),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign o_sts.data_lt     = (w_rd_data < r_res);
    assign o_sts.data_gt     = (w_rd_data > r_res);
    assign o_sts.search_done = (r_lo >= r_hi);
    assign o_sts.div_last    = (r_cnt == '0);

    assign w_hit      = (r_res == r_upper);
    assign w_min_ext  = DEG_W'($signed(i_cfg.min_degrees));
    assign w_max_ext  = DEG_W'($signed(i_cfg.max_degrees));
    assign w_deg_base = $signed(DEG_W'(r_lo)) + w_min_ext;
    assign w_prod     = NUM_W'(r_diff) * NUM_W'(i_cfg.scale);
    assign w_trial    = {1'b0, r_rem} - {1'b0, r_dsh};
    assign w_ge       = !w_trial[NUM_W];

    assign w_deg_ext   = TEMP_W'(r_deg);
    assign w_scale_ext = TEMP_W'($signed({1'b0, i_cfg.scale}));
    assign w_frac_ext  = r_use_frac ? $signed(TEMP_W'(r_quo)) : $signed(TEMP_W'(0));
    assign w_temp      = (w_deg_ext * w_scale_ext) + w_frac_ext;

    always_comb begin
        if (w_temp > $signed(TEMP_W'(OUT_MAX))) begin
            w_temp_sat = OUT_W'(OUT_MAX);
        end else if (w_temp < $signed(TEMP_W'(OUT_MIN))) begin
            w_temp_sat = OUT_W'(OUT_MIN);
        end else begin
            w_temp_sat = w_temp[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_req) begin
            r_res <= i_resistance;
        end
        if (i_cmd.clamp_min) begin
            r_deg      <= w_min_ext;
            r_use_frac <= 1'b0;
            r_status   <= CLAMP_MIN;
        end
        if (i_cmd.clamp_max) begin
            r_deg      <= w_max_ext;
            r_use_frac <= 1'b0;
            r_status   <= CLAMP_MAX;
        end
        if (i_cmd.init_search) begin
            r_lo <= '0;
            r_hi <= w_top;
        end
        if (i_cmd.step_search) begin
            if (w_rd_data < r_res) begin
                r_lo <= w_mid + IDX_W'(1);
            end else begin
                r_hi <= w_mid;
            end
        end
        if (i_cmd.ld_upper) begin
            r_upper <= w_rd_data;
        end
        if (i_cmd.ld_lower) begin
            r_deg      <= w_hit ? w_deg_base : (w_deg_base - DEG_W'(1));
            r_use_frac <= !w_hit;
            r_status   <= CLAMP_NONE;
            r_diff     <= r_res - w_rd_data;
            r_den      <= r_upper - w_rd_data;
        end
        if (i_cmd.ld_mul) begin
            r_rem <= w_prod;
            r_dsh <= NUM_W'(r_den) << (SCALE_W - 1);
            r_quo <= '0;
            r_cnt <= QCNT_W'(SCALE_W - 1);
        end
        if (i_cmd.div_step) begin
            if (w_ge) begin
                r_rem <= w_trial[NUM_W-1:0];
            end
            r_quo <= {r_quo[SCALE_W-2:0], w_ge};
            r_dsh <= r_dsh >> 1;
            r_cnt <= r_cnt - QCNT_W'(1);
        end
        if (i_cmd.ld_out) begin
            r_temp     <= w_temp_sat;
            r_stat_out <= r_status;
        end
    end

    assign o_temperature  = r_temp;
    assign o_clamp_status = r_stat_out;

endmodule

@@ design/rtd_resistance_to_temperature_core.sv @@
`timescale 1ns / 1ps

// Converts an RTD resistance in hundredths of an ohm to a temperature in degrees
// times scale, using a table of one resistance per whole degree held in a
// 1024-entry single-write, single-read RAM. A write item stores one table entry
// and leaves the block ready for the next item. A convert item runs a binary
// search (each probe a RAM read, then a compare) and then the seven-step
// restoring division of the interpolation; a clamped item skips both. Only one
// convert item is worked on at a time, and a finished result waits in an
// output register while the next item is accepted.
// The table must be written up to last_index before conversions are requested.
module rtd_resistance_to_temperature_core import rtd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_req_type,
    input  logic [9:0]               i_entry_index,
    input  logic [VAL_W-1:0]         i_entry_value,
    input  logic [VAL_W-1:0]         i_resistance,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [OUT_W-1:0]  o_temperature,
    output logic [STAT_W-1:0]        o_clamp_status,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [PDATA_W-1:0]       pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready
);

    logic [LI_W-1:0]    r_last_index;
    logic [MIN_W-1:0]   r_min_degrees;
    logic [MAX_W-1:0]   r_max_degrees;
    logic [SCALE_W-1:0] r_scale;
    logic               w_cfg_wr;
    t_cfg               w_cfg;
    t_cmd               w_cmd;
    t_sts               w_sts;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_index  <= RST_LAST_INDEX;
            r_min_degrees <= RST_MIN_DEGREES;
            r_max_degrees <= RST_MAX_DEGREES;
            r_scale       <= RST_SCALE;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_LAST_INDEX:  r_last_index  <= pwdata[LI_W-1:0];
                REG_MIN_DEGREES: r_min_degrees <= pwdata[MIN_W-1:0];
                REG_MAX_DEGREES: r_max_degrees <= pwdata[MAX_W-1:0];
                REG_SCALE:       r_scale       <= pwdata[SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_LAST_INDEX:  prdata = PDATA_W'(r_last_index);
            REG_MIN_DEGREES: prdata = PDATA_W'(r_min_degrees);
            REG_MAX_DEGREES: prdata = PDATA_W'(r_max_degrees);
            REG_SCALE:       prdata = PDATA_W'(r_scale);
            default:         prdata = '0;
        endcase
    end

    assign w_cfg.last_index  = r_last_index;
    assign w_cfg.min_degrees = r_min_degrees;
    assign w_cfg.max_degrees = r_max_degrees;
    assign w_cfg.scale       = r_scale;

    rtd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_req_type  (i_req_type),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    rtd_dpath u_dpath (
        .i_clk          (i_clk),
        .i_cfg          (w_cfg),
        .i_cmd          (w_cmd),
        .i_entry_index  (i_entry_index),
        .i_entry_value  (i_entry_value),
        .i_resistance   (i_resistance),
        .o_sts          (w_sts),
        .o_temperature  (o_temperature),
        .o_clamp_status (o_clamp_status)
    );

`ifndef NO_ASSERTIONS
    a_busy_after_convert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_req_type == REQ_CONVERT) |=> !o_in_ready)
        else $error("Block took another item right after a convert item.");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_req_type == REQ_WRITE) && !o_out_valid
        |=> !o_out_valid)
        else $error("A table write item produced a result.");

    a_no_write_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> !w_cmd.wr_entry)
        else $error("Table written while a conversion is in progress.");
`endif

endmodule

@@ sim/tb_rtd_resistance_to_temperature_core.sv @@
`timescale 1ns / 1ps

module tb_rtd_resistance_to_temperature_core;
    import rtd_pkg::*;

    localparam int SETTLE_CYCLES    = 50;
    localparam int MAX_REPORTS      = 10;
    localparam int PHASES           = 8;
    localparam int MIX_ITEMS        = 40;
    localparam int FIRST_LAST_INDEX = 127;

    localparam int SHAPE_RISING   = 0;
    localparam int SHAPE_REPEATS  = 1;
    localparam int SHAPE_UNSORTED = 2;

    typedef struct packed {
        logic             kind;
        logic [9:0]       entry_index;
        logic [VAL_W-1:0] entry_value;
        logic [VAL_W-1:0] resistance;
    } t_rtd_request;

    typedef struct packed {
        logic [OUT_W-1:0]  temperature;
        logic [STAT_W-1:0] clamp_status;
    } t_rtd_reading;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic                    i_req_type = REQ_WRITE;
    logic [9:0]              i_entry_index = '0;
    logic [VAL_W-1:0]        i_entry_value = '0;
    logic [VAL_W-1:0]        i_resistance = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic signed [OUT_W-1:0] o_temperature;
    logic [STAT_W-1:0]       o_clamp_status;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [PADDR_W-1:0]      paddr = '0;
    logic [PDATA_W-1:0]      pwdata = '0;
    logic [PDATA_W-1:0]      prdata;
    logic                    pready;

    t_rtd_request pending_requests[$];
    t_rtd_reading expected_readings[$];
    logic         request_taken = 1'b0;
    int           sender_idle_pct = 0;
    int           receiver_stall_pct = 0;

    logic [LI_W-1:0]           cfg_last_index = RST_LAST_INDEX;
    logic signed [MIN_W-1:0]   cfg_min_degrees = RST_MIN_DEGREES;
    logic signed [MAX_W-1:0]   cfg_max_degrees = RST_MAX_DEGREES;
    logic [SCALE_W-1:0]        cfg_scale = RST_SCALE;
    logic [VAL_W-1:0]          res_table [TABLE_DEPTH];
    int                        planned_table [TABLE_DEPTH];

    int mismatches = 0;
    int interpolated_count = 0;
    int low_clamp_count = 0;
    int high_clamp_count = 0;
    int register_writes = 0;
    int largest_table = 4;

    rtd_resistance_to_temperature_core dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic t_rtd_reading predict_reading(input logic [VAL_W-1:0] ohms);
        int r, top, lo, hi, mid, upper, lower, frac, temp, mn, mx, sc;
        t_rtd_reading rd;
        r = int'(ohms);
        mn = int'(cfg_min_degrees);
        mx = int'(cfg_max_degrees);
        sc = int'(cfg_scale);
        top = (cfg_last_index == 0) ? 1 : int'(cfg_last_index);
        if (r <= int'(res_table[0])) begin
            temp = mn * sc;
            rd.clamp_status = CLAMP_MIN;
        end else if (r >= int'(res_table[top])) begin
            temp = mx * sc;
            rd.clamp_status = CLAMP_MAX;
        end else begin
            lo = 0;
            hi = top;
            while (lo < hi) begin
                mid = (lo + hi) >> 1;
                if (int'(res_table[mid]) < r) begin
                    lo = mid + 1;
                end else begin
                    hi = mid;
                end
            end
            upper = int'(res_table[lo]);
            lower = int'(res_table[lo - 1]);
            if (r == upper) begin
                temp = (lo + mn) * sc;
            end else begin
                frac = (sc * (r - lower)) / (upper - lower);
                temp = (lo - 1 + mn) * sc + frac;
            end
            rd.clamp_status = CLAMP_NONE;
        end
        if (temp > OUT_MAX) begin
            temp = OUT_MAX;
        end else if (temp < OUT_MIN) begin
            temp = OUT_MIN;
        end
        rd.temperature = temp[OUT_W-1:0];
        return rd;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            request_taken = 1'b1;
            if (i_req_type == REQ_WRITE) begin
                res_table[i_entry_index] = i_entry_value;
            end else begin
                expected_readings.push_back(predict_reading(i_resistance));
            end
        end
    end

    always @(negedge i_clk) begin : drive_requests
        t_rtd_request req;
        if (!i_in_valid || request_taken) begin
            request_taken = 1'b0;
            if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                req = pending_requests.pop_front();
                i_req_type    <= req.kind;
                i_entry_index <= req.entry_index;
                i_entry_value <= req.entry_value;
                i_resistance  <= req.resistance;
                i_in_valid    <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge i_clk) begin : check_readings
        t_rtd_reading want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_readings.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("Unexpected result: temperature %0d status %0d",
                             o_temperature, o_clamp_status);
                end
            end else begin
                want = expected_readings.pop_front();
                case (want.clamp_status)
                    CLAMP_MIN: low_clamp_count++;
                    CLAMP_MAX: high_clamp_count++;
                    default:   interpolated_count++;
                endcase
                if (o_temperature !== want.temperature ||
                    o_clamp_status !== want.clamp_status) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display({"Mismatch: expected temperature %0d status %0d, ",
                                  "got %0d status %0d"},
                                 $signed(want.temperature), want.clamp_status,
                                 o_temperature, o_clamp_status);
                    end
                end
            end
        end
    end

    task automatic write_reg(input logic [1:0] reg_idx, input int value);
        logic [PDATA_W-1:0] word;
        word = $urandom;
        case (reg_idx)
            REG_LAST_INDEX:  word[LI_W-1:0]    = value[LI_W-1:0];
            REG_MIN_DEGREES: word[MIN_W-1:0]   = value[MIN_W-1:0];
            REG_MAX_DEGREES: word[MAX_W-1:0]   = value[MAX_W-1:0];
            default:         word[SCALE_W-1:0] = value[SCALE_W-1:0];
        endcase
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= word;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (reg_idx)
            REG_LAST_INDEX:  cfg_last_index  = word[LI_W-1:0];
            REG_MIN_DEGREES: cfg_min_degrees = word[MIN_W-1:0];
            REG_MAX_DEGREES: cfg_max_degrees = word[MAX_W-1:0];
            default:         cfg_scale       = word[SCALE_W-1:0];
        endcase
        register_writes++;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_idle();
        @(posedge i_clk);
        while (pending_requests.size() != 0 || i_in_valid || expected_readings.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_write(input int idx, input int val);
        t_rtd_request req;
        req.kind        = REQ_WRITE;
        req.entry_index = idx[9:0];
        req.entry_value = val[VAL_W-1:0];
        req.resistance  = VAL_W'($urandom);
        planned_table[idx] = val & 16'hFFFF;
        pending_requests.push_back(req);
    endtask

    task automatic push_convert(input int ohms);
        t_rtd_request req;
        req.kind        = REQ_CONVERT;
        req.entry_index = 10'($urandom);
        req.entry_value = VAL_W'($urandom);
        req.resistance  = ohms[VAL_W-1:0];
        pending_requests.push_back(req);
    endtask

    task automatic load_table(input int top, input int shape);
        int base, step_max, v;
        base = $urandom_range(20000);
        step_max = (65535 - base) / top;
        if (step_max > 3000) begin
            step_max = 3000;
        end
        v = base;
        for (int i = 0; i <= top; i++) begin
            if (shape == SHAPE_UNSORTED) begin
                v = $urandom_range(65535);
            end else if (i > 0) begin
                v += $urandom_range(step_max,
                                    (shape == SHAPE_REPEATS && $urandom_range(2) == 0) ? 0 : 1);
            end
            push_write(i, v);
        end
    endtask

    function automatic int pick_resistance(input int top);
        int a, b;
        a = planned_table[0];
        b = planned_table[top];
        case ($urandom_range(5))
            0: return planned_table[$urandom_range(top)];
            1: return (planned_table[$urandom_range(top)] + ($urandom_range(1) ? 1 : -1)) & 16'hFFFF;
            2: return $urandom_range(65535);
            3: begin
                case ($urandom_range(3))
                    0: return 0;
                    1: return 65535;
                    2: return a;
                    default: return b;
                endcase
            end
            default: return $urandom_range(a, b);
        endcase
    endfunction

    task automatic push_mix(input int top, input int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(4) == 0) begin
                if (top < TABLE_DEPTH - 1 && $urandom_range(1) == 1) begin
                    push_write($urandom_range(TABLE_DEPTH - 1, top + 1), $urandom_range(65535));
                end else begin
                    push_write($urandom_range(TABLE_DEPTH - 1), $urandom_range(65535));
                end
            end else begin
                push_convert(pick_resistance(top));
            end
        end
    endtask

    initial begin : stimulus
        int li, mn, mx, sc, top, shape;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        sender_idle_pct = 20;
        receiver_stall_pct = 20;
        write_reg(REG_LAST_INDEX, 3);
        write_reg(REG_MIN_DEGREES, -200);
        write_reg(REG_MAX_DEGREES, 823);
        write_reg(REG_SCALE, 10);
        push_write(0, 1000);
        push_write(1, 1390);
        push_write(2, 1780);
        push_write(3, 2170);
        push_convert(0);
        push_convert(1000);
        push_convert(1001);
        push_convert(1390);
        push_convert(1585);
        push_convert(2169);
        push_convert(2170);
        push_convert(65535);
        push_write(1023, 65535);
        push_write(512, 0);

        wait_idle();
        write_reg(REG_LAST_INDEX, 0);
        push_convert(1200);
        push_convert(1390);

        wait_idle();
        write_reg(REG_SCALE, 0);
        push_convert(1200);
        push_convert(500);

        wait_idle();
        write_reg(REG_LAST_INDEX, 3);
        write_reg(REG_SCALE, 127);
        write_reg(REG_MIN_DEGREES, -1024);
        write_reg(REG_MAX_DEGREES, 2047);
        push_convert(0);
        push_convert(65535);
        push_convert(1500);

        wait_idle();
        write_reg(REG_MIN_DEGREES, 1023);
        write_reg(REG_MAX_DEGREES, -2048);
        push_convert(2000);
        push_convert(3000);

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            case (p % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 83; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 83; end
                default: begin sender_idle_pct = 20; receiver_stall_pct = 20; end
            endcase
            if (p == 0) begin
                li = FIRST_LAST_INDEX;
            end else begin
                case ($urandom_range(9))
                    0: li = $urandom_range(1);
                    1: li = $urandom_range(60, 200);
                    default: li = $urandom_range(2, 24);
                endcase
            end
            mn = $urandom_range(1) ? int'($urandom_range(1123)) - 273
                                   : int'($urandom_range(2047)) - 1024;
            mx = $urandom_range(1) ? int'($urandom_range(1373)) - 273
                                   : int'($urandom_range(4095)) - 2048;
            if ($urandom_range(4) == 0) begin
                sc = $urandom_range(1) ? 0 : 127;
            end else begin
                sc = $urandom_range(1, 100);
            end
            write_reg(REG_LAST_INDEX, li);
            write_reg(REG_MIN_DEGREES, mn);
            write_reg(REG_MAX_DEGREES, mx);
            write_reg(REG_SCALE, sc);
            top = (li == 0) ? 1 : li;
            if (top + 1 > largest_table) begin
                largest_table = top + 1;
            end
            case (p % 5)
                3: shape = SHAPE_UNSORTED;
                4: shape = SHAPE_REPEATS;
                default: shape = SHAPE_RISING;
            endcase
            load_table(top, shape);
            push_mix(top, MIX_ITEMS);
        end

        wait_idle();
        $display("Checked %0d conversions: %0d interpolated, %0d clamped low, %0d clamped high.",
                 interpolated_count + low_clamp_count + high_clamp_count,
                 interpolated_count, low_clamp_count, high_clamp_count);
        $display("Tables of 2 to %0d entries, rising, repeated and unsorted, %0d register writes.",
                 largest_table, register_writes);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
design/rtd_pkg.sv
design/rtd_ram.sv
design/rtd_ctrl.sv
design/rtd_dpath.sv
design/rtd_resistance_to_temperature_core.sv
sim/tb_rtd_resistance_to_temperature_core.sv
